### src/rhpq_pkg.sv
// ---------------------------------------------------------------------------
// rhpq_pkg - shared types and codes for the radix heap priority queue
// opcodes, status codes and the front-to-back command record
// ---------------------------------------------------------------------------
package rhpq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_PULL   = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int OP_W  = 2;
    localparam int KEY_W = 16;
    localparam int PAY_W = 16;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } t_cmd;

endpackage

### src/rhpq_front.sv
// ---------------------------------------------------------------------------
// rhpq_front - input stage and command queue
// registers accepted items into a small fifo that feeds the engine
// ---------------------------------------------------------------------------
module rhpq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rhpq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output rhpq_pkg::t_cmd o_cmd
);
    rhpq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### src/radix_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// radix_heap_priority_queue - monotone radix heap of key/payload entries
// insert, pull-minimum and peek-minimum with linked bucket lists in memory
// ---------------------------------------------------------------------------
//  channel | signals                                   | dir
//  in      | i_valid i_ready i_opcode i_key i_payload  | in
//  out     | o_valid o_ready o_payload_out o_status    | out
//          | o_is_empty                                |
// flow: an item passes the input queue before the engine takes it; a pull or
//   peek that finds bucket 0 empty first redistributes the lowest non-empty
//   bucket, reading each entry of the moved bucket twice through the registered
//   entry memories (once for the minimum, once to move it)
// reset: synchronous; control then runs a free-list pass over all CAPACITY
//   entries before the first item is taken
// stalls: a two-entry queue decouples input; the result register holds
//   until taken, and the engine waits on it before it takes the next item
module radix_heap_priority_queue #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_key,
    input  logic [15:0] i_payload,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_payload_out,
    output logic [1:0]  o_status,
    output logic        o_is_empty
);
    localparam int KW = rhpq_pkg::KEY_W;
    localparam int NB = KW + 2;
    localparam int BW = $clog2(NB);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam int SW = KW + 1;
    localparam logic [SW-1:0] INF = {1'b1, {KW{1'b0}}};

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_INS = 4'd2,
        S_INS2 = 4'd3, S_PULL = 4'd4, S_PULL2 = 4'd5, S_FIND = 4'd6,
        S_MIN = 4'd7, S_MIN2 = 4'd8, S_REB = 4'd9, S_MOV = 4'd10,
        S_MOV2 = 4'd11, S_OUT = 4'd12;

    rhpq_pkg::t_cmd w_in, w_cmd;
    logic w_cvalid, w_cready;

    assign w_in = '{op: i_opcode, key: i_key, pay: i_payload};

    rhpq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(w_in),
        .o_valid(w_cvalid), .i_ready(w_cready), .o_cmd(w_cmd)
    );

    // entry memories
    logic [KW-1:0] m_key [CAPACITY];
    logic [15:0]   m_pay [CAPACITY];
    logic [PW-1:0] m_nxt [CAPACITY];

    logic [PW-1:0] r_head [NB];
    logic [PW-1:0] r_tail [NB];
    logic [SW-1:0] r_start [NB];
    logic [PW-1:0] r_free, r_cnt;
    logic [3:0]    r_st;
    logic [PW-1:0] r_init, r_e, r_walk;
    logic [BW-1:0] r_idx;
    logic [SW-1:0] r_mn;
    rhpq_pkg::t_cmd r_cmd;
    logic [KW-1:0] r_rkey;
    logic [15:0]   r_rpay;
    logic [PW-1:0] r_rnxt;
    logic          r_ov;
    logic [15:0]   r_opay;
    logic [1:0]    r_ost;
    logic          r_oemp;

    assign o_valid       = r_ov;
    assign o_payload_out = r_opay;
    assign o_status      = r_ost;
    assign o_is_empty    = r_oemp;
    assign w_cready      = (r_st == S_IDLE) && !r_ov;

    // bucket lookup for a key among buckets up to and including a limit
    function automatic logic [BW:0] f_find(logic [SW-1:0] st [NB], logic [KW-1:0] k,
                                           logic [BW-1:0] lim);
        logic [BW:0] b;
        b = '1;
        for (int i = 0; i < NB; i++) begin
            if (BW'(i) <= lim && st[i] <= {1'b0, k}) b = (BW+1)'(i);
        end
        return b;
    endfunction

    function automatic logic [SW-1:0] f_off(int i);
        if (i == 0) return '0;
        if (i == 1) return SW'(1);
        return SW'(1) << (i - 1);
    endfunction

    logic [BW:0] w_ib, w_mb;
    logic [BW-1:0] w_first;
    logic          w_any;
    assign w_ib = f_find(r_start, r_cmd.key, BW'(NB - 1));
    assign w_mb = f_find(r_start, r_rkey, r_idx);

    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (r_head[i] != NIL) begin
                w_first = BW'(i);
                w_any   = 1'b1;
            end
        end
    end

    // registered memory read of one entry
    always_ff @(posedge i_clk) begin
        r_rkey <= m_key[r_e[AW-1:0]];
        r_rpay <= m_pay[r_e[AW-1:0]];
        r_rnxt <= m_nxt[r_e[AW-1:0]];
    end

    logic          w_nwe;
    logic [AW-1:0] w_nadr;
    logic [PW-1:0] w_ndat;

    always_comb begin
        w_nwe  = 1'b0;
        w_nadr = r_e[AW-1:0];
        w_ndat = NIL;
        if (r_st == S_INIT) begin
            w_nwe  = 1'b1;
            w_nadr = r_init[AW-1:0];
            w_ndat = r_init + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nwe) m_nxt[w_nadr] <= w_ndat;
        if (!i_rst_n) begin
            r_st   <= S_INIT;
            r_init <= '0;
            r_free <= '0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
                r_start[i] <= (i == NB - 1) ? INF : f_off(i);
            end
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_INIT: begin
                    r_init <= r_init + PW'(1);
                    if (r_init == NIL - PW'(1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_cvalid && !r_ov) begin
                        r_cmd <= w_cmd;
                        r_opay <= '0;
                        r_ost <= rhpq_pkg::ST_OK;
                        r_oemp <= (r_cnt == '0);
                        if (w_cmd.op == rhpq_pkg::OP_INSERT) begin
                            r_e  <= r_free;
                            r_st <= S_INS;
                        end else if (w_cmd.op == rhpq_pkg::OP_PULL ||
                                     w_cmd.op == rhpq_pkg::OP_PEEK) begin
                            if (r_cnt == '0) begin
                                r_ost <= rhpq_pkg::ST_EMPTY;
                                r_st  <= S_OUT;
                            end else if (r_head[0] == NIL) begin
                                r_st <= S_FIND;
                            end else begin
                                r_e  <= r_head[0];
                                r_st <= S_PULL;
                            end
                        end else begin
                            r_st <= S_OUT;
                        end
                    end
                end
                S_INS: begin
                    if (w_ib[BW]) begin
                        r_ost <= rhpq_pkg::ST_BELOW;
                        r_st  <= S_OUT;
                    end else if (r_cnt == NIL || r_free == NIL) begin
                        r_ost <= rhpq_pkg::ST_FULL;
                        r_st  <= S_OUT;
                    end else begin
                        r_st <= S_INS2;
                    end
                end
                S_INS2: begin
                    // r_rnxt holds the next free entry
                    r_free <= r_rnxt;
                    m_key[r_e[AW-1:0]] <= r_cmd.key;
                    m_pay[r_e[AW-1:0]] <= r_cmd.pay;
                    m_nxt[r_e[AW-1:0]] <= NIL;
                    if (r_head[w_ib[BW-1:0]] == NIL) r_head[w_ib[BW-1:0]] <= r_e;
                    else m_nxt[r_tail[w_ib[BW-1:0]][AW-1:0]] <= r_e;
                    r_tail[w_ib[BW-1:0]] <= r_e;
                    r_cnt  <= r_cnt + PW'(1);
                    r_oemp <= 1'b0;
                    r_st   <= S_OUT;
                end
                S_FIND: begin
                    r_idx  <= w_first;
                    r_e    <= r_head[w_first];
                    r_walk <= r_head[w_first];
                    r_mn   <= INF;
                    r_st   <= w_any ? S_MIN : S_OUT;
                    if (!w_any) r_ost <= rhpq_pkg::ST_EMPTY;
                end
                S_MIN: r_st <= S_MIN2;
                S_MIN2: begin
                    if ({1'b0, r_rkey} < r_mn) r_mn <= {1'b0, r_rkey};
                    if (r_rnxt == NIL) begin
                        r_st <= S_REB;
                    end else begin
                        r_e  <= r_rnxt;
                        r_st <= S_MIN;
                    end
                end
                S_REB: begin
                    for (int i = 0; i < NB; i++) begin
                        if (BW'(i) < r_idx) r_start[i] <= r_mn + f_off(i);
                    end
                    r_start[r_idx] <= (32'(r_idx) < NB - 1) ?
                        r_start[r_idx + BW'(1)] : INF;
                    r_head[r_idx] <= NIL;
                    r_tail[r_idx] <= NIL;
                    r_e  <= r_walk;
                    r_st <= S_MOV;
                end
                S_MOV: r_st <= S_MOV2;
                S_MOV2: begin
                    m_nxt[r_e[AW-1:0]] <= NIL;
                    if (r_head[w_mb[BW-1:0]] == NIL) r_head[w_mb[BW-1:0]] <= r_e;
                    else m_nxt[r_tail[w_mb[BW-1:0]][AW-1:0]] <= r_e;
                    r_tail[w_mb[BW-1:0]] <= r_e;
                    if (r_rnxt == NIL) begin
                        // bucket 0 now holds the minimum
                        r_st <= S_PULL;
                        r_e  <= (w_mb[BW-1:0] == '0 && r_head[0] == NIL) ?
                                r_e : r_head[0];
                    end else begin
                        r_e  <= r_rnxt;
                        r_st <= S_MOV;
                    end
                end
                S_PULL: r_st <= S_PULL2;
                S_PULL2: begin
                    r_opay <= r_rpay;
                    if (r_cmd.op == rhpq_pkg::OP_PULL) begin
                        r_head[0] <= r_rnxt;
                        if (r_rnxt == NIL) r_tail[0] <= NIL;
                        m_nxt[r_e[AW-1:0]] <= r_free;
                        r_free <= r_e;
                        r_cnt  <= r_cnt - PW'(1);
                        r_oemp <= (r_cnt == PW'(1));
                        if (r_cnt == PW'(1)) begin
                            for (int i = 0; i < NB; i++)
                                r_start[i] <= (i == NB - 1) ? INF : f_off(i);
                        end
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NIL) else $error("entry count above capacity");
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rhpq_pkg::ST_EMPTY) |-> o_is_empty)
        else $error("empty status with entries left");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_payload_out)))
        else $error("result changed while stalled");
`endif
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - radix heap priority queue check
// drives a directed table and then random inserts, pulls and peeks through the
// valid/ready input, predicts each untyped result with its own radix heap and
// compares each result transfer field by field against the oldest prediction
// ---------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, answers current state
    localparam int KW       = rhpq_pkg::KEY_W;
    localparam int PWD      = rhpq_pkg::PAY_W;
    localparam int DEPTH    = 256;
    localparam int NB       = KW + 2;
    localparam int NIL      = DEPTH;
    localparam longint INF  = 64'd1 << 40;
    localparam int HOLD_CYC = 400;

    typedef struct packed {
        logic [PWD-1:0] pay;
        logic [1:0]     st;
        logic           emp;
    } t_result;

    typedef struct packed {
        logic [1:0]     op;
        logic [KW-1:0]  key;
        logic [PWD-1:0] pay;
        logic           typed;
        t_result        res;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    logic [1:0]     i_opcode;
    logic [KW-1:0]  i_key;
    logic [PWD-1:0] i_payload;
    logic           o_valid;
    logic           i_ready;
    logic [PWD-1:0] o_payload_out;
    logic [1:0]     o_status;
    logic           o_is_empty;

    // typed expectation travels with the item so the monitor sees it at transfer
    logic           cur_typed;
    t_result        cur_res;

    radix_heap_priority_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_key(i_key), .i_payload(i_payload),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_payload_out(o_payload_out), .o_status(o_status), .o_is_empty(o_is_empty)
    );

    // heap shadow
    logic [KW-1:0]  hp_key [DEPTH];
    logic [PWD-1:0] hp_pay [DEPTH];
    int             hp_next [DEPTH];
    int             bk_head [NB];
    int             bk_tail [NB];
    longint         bk_start [NB];
    int             free_ptr;
    int             live_cnt;

    t_result pending_results[$];
    int      errors;
    bit      calm;
    bit      hold_req;

    function automatic void set_starts(longint base, int n);
        for (int i = 0; i < n; i++)
            bk_start[i] = base + ((i == 0) ? 0 : (i == 1) ? 1 : (longint'(1) << (i - 1)));
    endfunction

    function automatic void clear_starts();
        set_starts(0, NB - 1);
        bk_start[NB-1] = INF;
    endfunction

    function automatic void chain_tail(int b, int e);
        hp_next[e] = NIL;
        if (bk_head[b] == NIL) bk_head[b] = e;
        else hp_next[bk_tail[b]] = e;
        bk_tail[b] = e;
    endfunction

    function automatic int bucket_of(longint k, int lim);
        for (int i = lim - 1; i >= 0; i--)
            if (bk_start[i] <= k) return i;
        return -1;
    endfunction

    function automatic void heap_clear();
        for (int i = 0; i < DEPTH; i++) hp_next[i] = i + 1;
        for (int i = 0; i < NB; i++) begin
            bk_head[i] = NIL;
            bk_tail[i] = NIL;
        end
        clear_starts();
        free_ptr = 0;
        live_cnt = 0;
    endfunction

    function automatic void spread_bucket();
        int idx;
        int e;
        int nx;
        int b;
        longint mn;
        idx = -1;
        for (int i = 0; i < NB; i++)
            if (idx < 0 && bk_head[i] != NIL) idx = i;
        if (idx <= 0) return;
        mn = INF;
        for (e = bk_head[idx]; e < NIL; e = hp_next[e])
            if (longint'(hp_key[e]) < mn) mn = longint'(hp_key[e]);
        set_starts(mn, idx);
        bk_start[idx] = (idx < NB - 1) ? bk_start[idx+1] : INF;
        e = bk_head[idx];
        bk_head[idx] = NIL;
        bk_tail[idx] = NIL;
        while (e < NIL) begin
            nx = hp_next[e];
            b = bucket_of(longint'(hp_key[e]), idx + 1);
            if (b < 0) b = 0;
            chain_tail(b, e);
            e = nx;
        end
    endfunction

    function automatic t_result heap_apply(logic [1:0] op, logic [KW-1:0] k,
                                           logic [PWD-1:0] p);
        t_result r;
        int b;
        int e;
        r = '0;
        r.st = rhpq_pkg::ST_OK;
        if (op == rhpq_pkg::OP_INSERT) begin
            b = bucket_of(longint'(k), NB);
            if (b < 0) r.st = rhpq_pkg::ST_BELOW;
            else if (live_cnt >= DEPTH || free_ptr >= NIL) r.st = rhpq_pkg::ST_FULL;
            else begin
                e = free_ptr;
                free_ptr = hp_next[e];
                hp_key[e] = k;
                hp_pay[e] = p;
                chain_tail(b, e);
                live_cnt++;
            end
        end else if (op == rhpq_pkg::OP_PULL || op == rhpq_pkg::OP_PEEK) begin
            if (live_cnt == 0) r.st = rhpq_pkg::ST_EMPTY;
            else begin
                if (bk_head[0] == NIL) spread_bucket();
                if (bk_head[0] == NIL) r.st = rhpq_pkg::ST_EMPTY;
                else begin
                    e = bk_head[0];
                    r.pay = hp_pay[e];
                    if (op == rhpq_pkg::OP_PULL) begin
                        bk_head[0] = hp_next[e];
                        if (bk_head[0] == NIL) bk_tail[0] = NIL;
                        hp_next[e] = free_ptr;
                        free_ptr = e;
                        live_cnt--;
                        if (live_cnt == 0) clear_starts();
                    end
                end
            end
        end
        r.emp = (live_cnt == 0);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("FAIL radix_heap_priority_queue");
        $finish;
    end

    // transfer monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_result p;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                p = heap_apply(i_opcode, i_key, i_payload);
                pending_results.push_back(cur_typed ? cur_res : p);
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected: pay %h st %0d emp %0d",
                             $time, o_payload_out, o_status, o_is_empty);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.pay !== o_payload_out) begin
                        $display("%0t: payload_out expected %h actual %h",
                                 $time, want.pay, o_payload_out);
                        errors++;
                    end
                    if (want.st !== o_status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, o_status);
                        errors++;
                    end
                    if (want.emp !== o_is_empty) begin
                        $display("%0t: is_empty expected %0d actual %0d",
                                 $time, want.emp, o_is_empty);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [KW-1:0] k, logic [PWD-1:0] p,
                             logic typed, t_result r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_key     <= k;
        i_payload <= p;
        cur_typed <= typed;
        cur_res   <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [KW-1:0] pick_key();
        longint k;
        case ($urandom_range(0, 9))
            0, 1: k = longint'($urandom_range(0, 16'hFFFF));
            2:    k = $urandom_range(0, 1) ? 64'hFFFF : 64'h0000;
            default: k = bk_start[0] +
                         longint'($urandom_range(0, (1 << $urandom_range(0, 16)) - 1));
        endcase
        if (k > 16'hFFFF) k = 16'hFFFF;
        return k[KW-1:0];
    endfunction

    // weights in percent for insert, pull, peek; the rest is the unused opcode
    task automatic random_run(int n, int w_ins, int w_pull, int w_peek);
        int d;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, 99);
            if (d < w_ins) op = rhpq_pkg::OP_INSERT;
            else if (d < w_ins + w_pull) op = rhpq_pkg::OP_PULL;
            else if (d < w_ins + w_pull + w_peek) op = rhpq_pkg::OP_PEEK;
            else op = OP_NONE;
            send_item(op, pick_key(), PWD'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    t_row dir_rows[] = '{
        '{rhpq_pkg::OP_PEEK, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, rhpq_pkg::ST_EMPTY, 1'b1}},
        '{rhpq_pkg::OP_PULL, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, rhpq_pkg::ST_EMPTY, 1'b1}},
        '{OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b1}},
        '{rhpq_pkg::OP_INSERT, 16'h0000, 16'hFFFF, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        '{rhpq_pkg::OP_PEEK, 16'h0000, 16'h0000, 1'b1,
          '{16'hFFFF, rhpq_pkg::ST_OK, 1'b0}},
        '{OP_NONE, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        '{rhpq_pkg::OP_PULL, 16'h0000, 16'h0000, 1'b1,
          '{16'hFFFF, rhpq_pkg::ST_OK, 1'b1}},
        '{rhpq_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        '{rhpq_pkg::OP_INSERT, 16'h8000, 16'hAAAA, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        '{rhpq_pkg::OP_INSERT, 16'h7FFF, 16'h5555, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        // redistribution: lowest non-empty bucket holds 7fff
        '{rhpq_pkg::OP_PULL, 16'h0000, 16'h0000, 1'b1,
          '{16'h5555, rhpq_pkg::ST_OK, 1'b0}},
        // range now starts at 7fff, so key 0 is below it
        '{rhpq_pkg::OP_INSERT, 16'h0000, 16'h1234, 1'b1,
          '{16'h0000, rhpq_pkg::ST_BELOW, 1'b0}},
        '{rhpq_pkg::OP_INSERT, 16'h8000, 16'h0001, 1'b0, '0},
        '{rhpq_pkg::OP_INSERT, 16'h9000, 16'h0002, 1'b0, '0},
        '{rhpq_pkg::OP_PEEK,   16'h0000, 16'h0000, 1'b0, '0},
        '{rhpq_pkg::OP_PULL,   16'h0000, 16'h0000, 1'b0, '0},
        '{rhpq_pkg::OP_PULL,   16'h0000, 16'h0000, 1'b0, '0},
        '{rhpq_pkg::OP_PULL,   16'h0000, 16'h0000, 1'b0, '0},
        '{rhpq_pkg::OP_PULL,   16'h0000, 16'h0000, 1'b0, '0},
        // heap emptied, ranges back to base 0
        '{rhpq_pkg::OP_PULL, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, rhpq_pkg::ST_EMPTY, 1'b1}},
        '{rhpq_pkg::OP_INSERT, 16'h0001, 16'h0F0F, 1'b1,
          '{16'h0000, rhpq_pkg::ST_OK, 1'b0}},
        '{rhpq_pkg::OP_PULL, 16'h0000, 16'h0000, 1'b1,
          '{16'h0F0F, rhpq_pkg::ST_OK, 1'b1}}
    };

    initial begin
        errors    = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_opcode  = rhpq_pkg::OP_INSERT;
        i_key     = '0;
        i_payload = '0;
        cur_typed = 1'b0;
        cur_res   = '0;
        heap_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pay,
                      dir_rows[i].typed, dir_rows[i].res);

        random_run(400, 50, 30, 15);

        // fill past capacity, opening with a long receiver hold-off
        hold_req = 1'b1;
        random_run(290, 95, 0, 5);

        // sender pause until every result is back
        wait_drained();
        random_run(300, 10, 75, 15);

        calm = 1'b1;
        random_run(70, 45, 35, 15);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("PASS radix_heap_priority_queue");
        else
            $display("FAIL radix_heap_priority_queue");
        $finish;
    end

endmodule
